// ===== rtl/core/usbep0_pkg.sv =====
// Shared types, codes and constants for the endpoint-0 control engine.
`timescale 1ns / 1ps

package usbep0_pkg;

    localparam int MAX_PACKET  = 64;
    localparam int MAX_STRINGS = 4;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    // events
    localparam logic [2:0] EV_BUS_RESET = 3'd0;
    localparam logic [2:0] EV_SETUP     = 3'd1;
    localparam logic [2:0] EV_OUT_DONE  = 3'd2;
    localparam logic [2:0] EV_IN_DONE   = 3'd3;
    localparam logic [2:0] EV_STALL     = 3'd4;

    // endpoint actions
    localparam logic [2:0] ACT_SETUP = 3'd0;
    localparam logic [2:0] ACT_STALL = 3'd1;
    localparam logic [2:0] ACT_IN    = 3'd2;
    localparam logic [2:0] ACT_OUT   = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    // reply sources
    localparam logic [2:0] SRC_NONE   = 3'd0;
    localparam logic [2:0] SRC_DEVICE = 3'd1;
    localparam logic [2:0] SRC_CONFIG = 3'd2;
    localparam logic [2:0] SRC_STRING = 3'd3;
    localparam logic [2:0] SRC_ZERO   = 3'd4;

    // control phases
    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_IN    = 2'd1;
    localparam logic [1:0] PH_OUT   = 2'd2;

    // device states
    localparam logic [1:0] ST_POWERED    = 2'd0;
    localparam logic [1:0] ST_DEFAULT    = 2'd1;
    localparam logic [1:0] ST_ADDRESS    = 2'd2;
    localparam logic [1:0] ST_CONFIGURED = 2'd3;

    // standard requests
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_SET_DEV_ADDR      = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;

    localparam logic [7:0] RT_STD_DEVICE_IN = 8'h80;
    localparam logic [7:0] RT_RECIPIENT     = 8'h1F;

    // descriptor types
    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    // register indexes
    localparam logic [2:0] REG_DEVICE_DESC_LENGTH  = 3'd0;
    localparam logic [2:0] REG_CONFIG_TOTAL_LENGTH = 3'd1;
    localparam logic [2:0] REG_STRING_COUNT        = 3'd2;
    localparam logic [2:0] REG_STRING0_LENGTH      = 3'd3;
    localparam logic [2:0] REG_STRING1_LENGTH      = 3'd4;
    localparam logic [2:0] REG_STRING2_LENGTH      = 3'd5;
    localparam logic [2:0] REG_STRING3_LENGTH      = 3'd6;

    typedef struct packed {
        logic [7:0]                   device_desc_length;
        logic [15:0]                  config_total_length;
        logic [2:0]                   string_count;
        logic [MAX_STRINGS-1:0][7:0]  string_length;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value;
        logic [15:0] length;
        logic [6:0]  out_count;
    } item_t;

    typedef struct packed {
        logic [2:0]  ep0_action;
        logic [6:0]  in_count;
        logic [2:0]  source_select;
        logic [1:0]  string_index;
        logic [15:0] source_offset;
        logic        packet_toggle;
        logic [15:0] out_total;
        logic [1:0]  device_state;
        logic [7:0]  bus_address;
        logic [7:0]  configuration;
    } res_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] remaining;
        logic [15:0] offset;
        logic [2:0]  source;
        logic [1:0]  string_sel;
        logic        in_toggle;
        logic        out_toggle;
        logic [15:0] out_accum;
        logic [1:0]  dev_state;
        logic [7:0]  address;
        logic [7:0]  last_value_low;
        logic [7:0]  config_value;
    } state_t;

endpackage

// ===== rtl/core/usbep0_regs.sv =====
// Configuration registers behind the APB port.
`timescale 1ns / 1ps

module usbep0_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [usbep0_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output usbep0_pkg::cfg_t                   cfg
);

    usbep0_pkg::cfg_t                 cfg_reg;
    logic [usbep0_pkg::REG_IDX_W-1:0] idx;
    logic                             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[usbep0_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_desc_length  <= 8'd18;
            cfg_reg.config_total_length <= 16'd9;
            cfg_reg.string_count        <= 3'd0;
            cfg_reg.string_length       <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                usbep0_pkg::REG_DEVICE_DESC_LENGTH:  cfg_reg.device_desc_length  <= pwdata[7:0];
                usbep0_pkg::REG_CONFIG_TOTAL_LENGTH: cfg_reg.config_total_length <= pwdata[15:0];
                usbep0_pkg::REG_STRING_COUNT:        cfg_reg.string_count        <= pwdata[2:0];
                usbep0_pkg::REG_STRING0_LENGTH:      cfg_reg.string_length[0]    <= pwdata[7:0];
                usbep0_pkg::REG_STRING1_LENGTH:      cfg_reg.string_length[1]    <= pwdata[7:0];
                usbep0_pkg::REG_STRING2_LENGTH:      cfg_reg.string_length[2]    <= pwdata[7:0];
                usbep0_pkg::REG_STRING3_LENGTH:      cfg_reg.string_length[3]    <= pwdata[7:0];
                default:                             ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            usbep0_pkg::REG_DEVICE_DESC_LENGTH:  prdata = {24'd0, cfg_reg.device_desc_length};
            usbep0_pkg::REG_CONFIG_TOTAL_LENGTH: prdata = {16'd0, cfg_reg.config_total_length};
            usbep0_pkg::REG_STRING_COUNT:        prdata = {29'd0, cfg_reg.string_count};
            usbep0_pkg::REG_STRING0_LENGTH:      prdata = {24'd0, cfg_reg.string_length[0]};
            usbep0_pkg::REG_STRING1_LENGTH:      prdata = {24'd0, cfg_reg.string_length[1]};
            usbep0_pkg::REG_STRING2_LENGTH:      prdata = {24'd0, cfg_reg.string_length[2]};
            usbep0_pkg::REG_STRING3_LENGTH:      prdata = {24'd0, cfg_reg.string_length[3]};
            default:                             prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/usbep0_core.sv =====
// Control-transfer state and the single-pass event decode.
`timescale 1ns / 1ps

module usbep0_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  usbep0_pkg::item_t  item,
    input  usbep0_pkg::cfg_t   cfg,
    output usbep0_pkg::res_t   res
);

    usbep0_pkg::state_t state_reg;
    usbep0_pkg::state_t state_next;

    always_comb
    begin
        logic        do_pkt;
        logic        ok;
        logic [15:0] setup_len;
        logic [7:0]  vlow;
        logic [7:0]  dtype;
        logic [16:0] sum;
        logic [6:0]  cnt;

        state_next = state_reg;
        do_pkt     = 1'b0;
        ok         = 1'b0;
        setup_len  = 16'd0;
        vlow       = item.value[7:0];
        dtype      = item.value[15:8];
        sum        = {1'b0, state_reg.out_accum} + {10'd0, item.out_count};
        cnt        = 7'd0;

        res.ep0_action    = usbep0_pkg::ACT_NONE;
        res.in_count      = 7'd0;
        res.source_select = usbep0_pkg::SRC_NONE;
        res.string_index  = 2'd0;
        res.source_offset = 16'd0;
        res.packet_toggle = 1'b0;

        case (item.req_type)
            usbep0_pkg::EV_BUS_RESET:
            begin
                state_next.address      = 8'd0;
                state_next.config_value = 8'd0;
                state_next.dev_state    = usbep0_pkg::ST_DEFAULT;
                state_next.remaining    = 16'd0;
                state_next.offset       = 16'd0;
                state_next.source       = usbep0_pkg::SRC_NONE;
                state_next.string_sel   = 2'd0;
                state_next.out_accum    = 16'd0;
                state_next.phase        = usbep0_pkg::PH_SETUP;
                res.ep0_action          = usbep0_pkg::ACT_SETUP;
            end
            usbep0_pkg::EV_SETUP:
            begin
                state_next.last_value_low = vlow;
                state_next.phase          = usbep0_pkg::PH_SETUP;
                state_next.out_accum      = 16'd0;
                state_next.source         = usbep0_pkg::SRC_NONE;
                state_next.string_sel     = 2'd0;
                state_next.offset         = 16'd0;
                case (item.request_code)
                    usbep0_pkg::REQ_SET_DEV_ADDR:
                    begin
                        ok                   = 1'b1;
                        state_next.dev_state = usbep0_pkg::ST_ADDRESS;
                    end
                    usbep0_pkg::REQ_GET_DESCRIPTOR:
                    begin
                        if (item.request_type == usbep0_pkg::RT_STD_DEVICE_IN)
                        begin
                            case (dtype)
                                usbep0_pkg::DT_DEVICE:
                                begin
                                    ok                = 1'b1;
                                    state_next.source = usbep0_pkg::SRC_DEVICE;
                                    setup_len         = {8'd0, cfg.device_desc_length};
                                end
                                usbep0_pkg::DT_CONFIG:
                                begin
                                    ok                = 1'b1;
                                    state_next.source = usbep0_pkg::SRC_CONFIG;
                                    setup_len         = cfg.config_total_length;
                                end
                                usbep0_pkg::DT_STRING:
                                begin
                                    if ((vlow < {5'd0, cfg.string_count}) &&
                                        (vlow < 8'(usbep0_pkg::MAX_STRINGS)))
                                    begin
                                        ok                    = 1'b1;
                                        state_next.source     = usbep0_pkg::SRC_STRING;
                                        state_next.string_sel = vlow[1:0];
                                        setup_len = {8'd0, cfg.string_length[vlow[1:0]]};
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    usbep0_pkg::REQ_GET_STATUS:
                    begin
                        if ((item.request_type & usbep0_pkg::RT_RECIPIENT) == 8'd0)
                        begin
                            ok                = 1'b1;
                            state_next.source = usbep0_pkg::SRC_ZERO;
                            setup_len         = 16'd2;
                        end
                    end
                    usbep0_pkg::REQ_SET_CONFIGURATION:
                    begin
                        ok                      = 1'b1;
                        state_next.config_value = vlow;
                        state_next.dev_state    = (vlow == 8'd0) ? usbep0_pkg::ST_ADDRESS
                                                                 : usbep0_pkg::ST_CONFIGURED;
                    end
                    usbep0_pkg::REQ_GET_INTERFACE:
                    begin
                        ok                = 1'b1;
                        state_next.source = usbep0_pkg::SRC_ZERO;
                        setup_len         = 16'd1;
                    end
                    default: ;
                endcase

                if (!ok)
                begin
                    state_next.remaining  = 16'd0;
                    state_next.source     = usbep0_pkg::SRC_NONE;
                    state_next.string_sel = 2'd0;
                    res.ep0_action        = usbep0_pkg::ACT_STALL;
                end
                else if (item.request_type[7])
                begin
                    state_next.remaining = (item.length < setup_len) ? item.length : setup_len;
                    state_next.in_toggle = 1'b1;
                    state_next.phase     = usbep0_pkg::PH_IN;
                    do_pkt               = 1'b1;
                end
                else
                begin
                    state_next.remaining  = 16'd0;
                    state_next.source     = usbep0_pkg::SRC_NONE;
                    state_next.string_sel = 2'd0;
                    state_next.out_toggle = 1'b1;
                    state_next.phase      = usbep0_pkg::PH_OUT;
                    res.ep0_action        = usbep0_pkg::ACT_OUT;
                    res.packet_toggle     = 1'b1;
                end
            end
            usbep0_pkg::EV_OUT_DONE:
            begin
                if (state_reg.phase == usbep0_pkg::PH_OUT)
                begin
                    state_next.out_accum  = sum[16] ? 16'hFFFF : sum[15:0];
                    state_next.out_toggle = !state_reg.out_toggle;
                    res.ep0_action        = usbep0_pkg::ACT_OUT;
                    res.packet_toggle     = !state_reg.out_toggle;
                end
                else
                begin
                    state_next.phase = usbep0_pkg::PH_SETUP;
                    res.ep0_action   = usbep0_pkg::ACT_SETUP;
                end
            end
            usbep0_pkg::EV_IN_DONE:
            begin
                // apply the pending address at the status stage
                if ((state_reg.address == 8'd0) &&
                    (state_reg.dev_state == usbep0_pkg::ST_ADDRESS))
                begin
                    state_next.address = state_reg.last_value_low;
                    if (state_reg.last_value_low == 8'd0)
                    begin
                        state_next.dev_state = usbep0_pkg::ST_DEFAULT;
                    end
                end
                if (state_reg.phase == usbep0_pkg::PH_IN)
                begin
                    state_next.in_toggle = !state_reg.in_toggle;
                    do_pkt               = 1'b1;
                end
                else
                begin
                    state_next.phase = usbep0_pkg::PH_SETUP;
                    res.ep0_action   = usbep0_pkg::ACT_SETUP;
                end
            end
            usbep0_pkg::EV_STALL:
            begin
                state_next.phase = usbep0_pkg::PH_SETUP;
                res.ep0_action   = usbep0_pkg::ACT_SETUP;
            end
            default: ;
        endcase

        // cut the next packet from the pending reply
        if (do_pkt)
        begin
            cnt = (state_next.remaining < 16'(usbep0_pkg::MAX_PACKET))
                ? state_next.remaining[6:0] : 7'(usbep0_pkg::MAX_PACKET);
            res.ep0_action       = usbep0_pkg::ACT_IN;
            res.in_count         = cnt;
            res.source_select    = state_next.source;
            res.string_index     = (state_next.source == usbep0_pkg::SRC_STRING)
                                 ? state_next.string_sel : 2'd0;
            res.source_offset    = state_next.offset;
            res.packet_toggle    = state_next.in_toggle;
            state_next.remaining = state_next.remaining - {9'd0, cnt};
            state_next.offset    = state_next.offset + {9'd0, cnt};
        end

        res.out_total     = state_next.out_accum;
        res.device_state  = state_next.dev_state;
        res.bus_address   = state_next.address;
        res.configuration = state_next.config_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= usbep0_pkg::PH_SETUP;
            state_reg.remaining      <= 16'd0;
            state_reg.offset         <= 16'd0;
            state_reg.source         <= usbep0_pkg::SRC_NONE;
            state_reg.string_sel     <= 2'd0;
            state_reg.in_toggle      <= 1'b0;
            state_reg.out_toggle     <= 1'b0;
            state_reg.out_accum      <= 16'd0;
            state_reg.dev_state      <= usbep0_pkg::ST_POWERED;
            state_reg.address        <= 8'd0;
            state_reg.last_value_low <= 8'd0;
            state_reg.config_value   <= 8'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    a_stall_arms_setup: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.req_type == usbep0_pkg::EV_STALL) |=> state_reg.phase == usbep0_pkg::PH_SETUP)
        else $error("stall event left the control phase open");

    a_bus_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.req_type == usbep0_pkg::EV_BUS_RESET)
        |=> (state_reg.address == 8'd0) && (state_reg.dev_state == usbep0_pkg::ST_DEFAULT))
        else $error("bus reset did not clear address and state");

    a_in_drains: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.req_type == usbep0_pkg::EV_IN_DONE)
        |=> state_reg.remaining <= $past(state_reg.remaining))
        else $error("remaining length grew on an IN completion");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.ep0_action != usbep0_pkg::ACT_IN)
        |-> (res.in_count == 7'd0) && (res.source_select == usbep0_pkg::SRC_NONE))
        else $error("packet fields set on a non-IN action");

endmodule

// ===== rtl/core/usb_ep0_control_request_engine.sv =====
// Top level of the endpoint-0 control engine: streams, APB port and result register.
`timescale 1ns / 1ps

// One endpoint-0 event enters per item on the s_ side and yields exactly one
// result item on the m_ side telling how endpoint 0 is armed next. The block
// takes one item every cycle unless the result output stalls; an accepted item
// goes to the input register, then its result to the result register loaded by
// the single decode and state-update pass. A stalled result output holds one
// item while one more waits in the input register. The user must write configuration
// through the APB port while no item is in flight; the block does not enforce it. No clearing pass follows reset.
module usb_ep0_control_request_engine
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // request_type[7:0], request_code[15:8], value[31:16], length[47:32],
    // out_count[54:48], zero[55]
    input  logic [55:0]                        s_tdata,
    // req_type[2:0]
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // in_count[6:0], source_select[9:7], string_index[11:10], source_offset[27:12],
    // packet_toggle[28], out_total[44:29], device_state[46:45], bus_address[54:47],
    // configuration[62:55], zero[63]
    output logic [63:0]                        m_tdata,
    // ep0_action[2:0]
    output logic [2:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [usbep0_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    usbep0_pkg::cfg_t  cfg;
    usbep0_pkg::item_t item_reg;
    usbep0_pkg::res_t  res;
    usbep0_pkg::res_t  res_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              out_valid_reg;
    logic              advance;
    logic              fire;

    usbep0_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    usbep0_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // hold the item and the result without reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req_type     <= s_tuser;
            item_reg.request_type <= s_tdata[7:0];
            item_reg.request_code <= s_tdata[15:8];
            item_reg.value        <= s_tdata[31:16];
            item_reg.length       <= s_tdata[47:32];
            item_reg.out_count    <= s_tdata[54:48];
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.ep0_action;
    assign m_tdata  = {1'b0, res_reg.configuration, res_reg.bus_address,
                       res_reg.device_state, res_reg.out_total, res_reg.packet_toggle,
                       res_reg.source_offset, res_reg.string_index,
                       res_reg.source_select, res_reg.in_count};

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the endpoint-0 control engine: scoreboard, random control transfers.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_EVENTS = 600;
    localparam int SETTLE_CYCLES = 4;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [55:0]                       s_tdata  = '0;
    logic [2:0]                        s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [63:0]                       m_tdata;
    logic [2:0]                        m_tuser;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [usbep0_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]                       pwdata   = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    usb_ep0_control_request_engine u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // engine model: register copy
    logic [7:0]  dev_desc_len;
    logic [15:0] cfg_set_len;
    logic [2:0]  str_count;
    logic [7:0]  str_len [usbep0_pkg::MAX_STRINGS];

    // engine model: control state
    logic [1:0]  ctl_phase;
    logic [15:0] reply_left;
    logic [15:0] reply_offset;
    logic [2:0]  reply_source;
    logic [1:0]  reply_string;
    logic        in_tog;
    logic        out_tog;
    logic [15:0] out_bytes;
    logic [1:0]  dev_st;
    logic [7:0]  dev_addr;
    logic [7:0]  pending_addr;
    logic [7:0]  cur_cfg;

    usbep0_pkg::res_t pending_arms [$];
    usbep0_pkg::res_t want;

    int errors        = 0;
    int events_sent   = 0;
    int cycles        = 0;
    int burst_left    = 0;
    int reg_writes    = 0;
    int settings_used = 0;
    int seen_in       = 0;
    int seen_out      = 0;
    int seen_stall    = 0;
    int seen_setup    = 0;
    int seen_none     = 0;
    int rdy_span      = 0;
    int rdy_mode      = 0;
    int rdy_phase     = 0;

    function automatic void reset_engine_model();
        dev_desc_len = 8'd18;
        cfg_set_len  = 16'd9;
        str_count    = 3'd0;
        for (int i = 0; i < usbep0_pkg::MAX_STRINGS; i++)
        begin
            str_len[i] = 8'd0;
        end
        ctl_phase    = usbep0_pkg::PH_SETUP;
        reply_left   = '0;
        reply_offset = '0;
        reply_source = usbep0_pkg::SRC_NONE;
        reply_string = '0;
        in_tog       = 1'b0;
        out_tog      = 1'b0;
        out_bytes    = '0;
        dev_st       = usbep0_pkg::ST_POWERED;
        dev_addr     = '0;
        pending_addr = '0;
        cur_cfg      = '0;
    endfunction

    function automatic usbep0_pkg::res_t arming(input logic [2:0] act, input logic [6:0] cnt,
                                                input logic [2:0] src, input logic [1:0] sidx,
                                                input logic [15:0] off, input logic tog);
        usbep0_pkg::res_t r;
        r.ep0_action    = act;
        r.in_count      = cnt;
        r.source_select = src;
        r.string_index  = (src == usbep0_pkg::SRC_STRING) ? sidx : 2'd0;
        r.source_offset = off;
        r.packet_toggle = tog;
        r.out_total     = out_bytes;
        r.device_state  = dev_st;
        r.bus_address   = dev_addr;
        r.configuration = cur_cfg;
        return r;
    endfunction

    function automatic usbep0_pkg::res_t next_in_packet();
        logic [15:0] cnt;
        logic [15:0] off;
        cnt = (reply_left < usbep0_pkg::MAX_PACKET) ? reply_left
                                                    : 16'(usbep0_pkg::MAX_PACKET);
        off = reply_offset;
        reply_left   = reply_left - cnt;
        reply_offset = reply_offset + cnt;
        return arming(usbep0_pkg::ACT_IN, cnt[6:0], reply_source, reply_string, off, in_tog);
    endfunction

    function automatic usbep0_pkg::res_t arm_for_setup();
        ctl_phase = usbep0_pkg::PH_SETUP;
        return arming(usbep0_pkg::ACT_SETUP, '0, usbep0_pkg::SRC_NONE, '0, '0, 1'b0);
    endfunction

    function automatic usbep0_pkg::res_t decode_setup(input usbep0_pkg::item_t it);
        logic [7:0]  vlow;
        logic [7:0]  dtype;
        logic        ok;
        logic [15:0] len;
        vlow  = it.value[7:0];
        dtype = it.value[15:8];
        ok    = 1'b0;
        len   = '0;
        pending_addr = vlow;
        ctl_phase    = usbep0_pkg::PH_SETUP;
        out_bytes    = '0;
        reply_source = usbep0_pkg::SRC_NONE;
        reply_string = '0;
        reply_offset = '0;
        case (it.request_code)
            usbep0_pkg::REQ_SET_DEV_ADDR:
            begin
                ok     = 1'b1;
                dev_st = usbep0_pkg::ST_ADDRESS;
            end
            usbep0_pkg::REQ_GET_DESCRIPTOR:
            begin
                if (it.request_type == usbep0_pkg::RT_STD_DEVICE_IN)
                begin
                    if (dtype == usbep0_pkg::DT_DEVICE)
                    begin
                        ok           = 1'b1;
                        reply_source = usbep0_pkg::SRC_DEVICE;
                        len          = {8'd0, dev_desc_len};
                    end
                    else if (dtype == usbep0_pkg::DT_CONFIG)
                    begin
                        ok           = 1'b1;
                        reply_source = usbep0_pkg::SRC_CONFIG;
                        len          = cfg_set_len;
                    end
                    else if (dtype == usbep0_pkg::DT_STRING && vlow < {5'd0, str_count}
                             && vlow < usbep0_pkg::MAX_STRINGS)
                    begin
                        ok           = 1'b1;
                        reply_source = usbep0_pkg::SRC_STRING;
                        reply_string = vlow[1:0];
                        len          = {8'd0, str_len[vlow[1:0]]};
                    end
                end
            end
            usbep0_pkg::REQ_GET_STATUS:
            begin
                if ((it.request_type & usbep0_pkg::RT_RECIPIENT) == 8'h00)
                begin
                    ok           = 1'b1;
                    reply_source = usbep0_pkg::SRC_ZERO;
                    len          = 16'd2;
                end
            end
            usbep0_pkg::REQ_SET_CONFIGURATION:
            begin
                ok      = 1'b1;
                cur_cfg = vlow;
                dev_st  = (vlow == 8'd0) ? usbep0_pkg::ST_ADDRESS : usbep0_pkg::ST_CONFIGURED;
            end
            usbep0_pkg::REQ_GET_INTERFACE:
            begin
                ok           = 1'b1;
                reply_source = usbep0_pkg::SRC_ZERO;
                len          = 16'd1;
            end
            default:
            begin
            end
        endcase
        if (!ok)
        begin
            reply_left   = '0;
            reply_source = usbep0_pkg::SRC_NONE;
            reply_string = '0;
            return arming(usbep0_pkg::ACT_STALL, '0, usbep0_pkg::SRC_NONE, '0, '0, 1'b0);
        end
        if (it.request_type[7])
        begin
            reply_left = (it.length < len) ? it.length : len;
            in_tog     = 1'b1;
            ctl_phase  = usbep0_pkg::PH_IN;
            return next_in_packet();
        end
        reply_left   = '0;
        reply_source = usbep0_pkg::SRC_NONE;
        reply_string = '0;
        out_tog      = 1'b1;
        ctl_phase    = usbep0_pkg::PH_OUT;
        return arming(usbep0_pkg::ACT_OUT, '0, usbep0_pkg::SRC_NONE, '0, '0, out_tog);
    endfunction

    function automatic usbep0_pkg::res_t predict_arming(input usbep0_pkg::item_t it);
        logic [16:0] sum;
        case (it.req_type)
            usbep0_pkg::EV_BUS_RESET:
            begin
                dev_addr     = '0;
                cur_cfg      = '0;
                dev_st       = usbep0_pkg::ST_DEFAULT;
                reply_left   = '0;
                reply_offset = '0;
                reply_source = usbep0_pkg::SRC_NONE;
                reply_string = '0;
                out_bytes    = '0;
                return arm_for_setup();
            end
            usbep0_pkg::EV_SETUP:
            begin
                return decode_setup(it);
            end
            usbep0_pkg::EV_OUT_DONE:
            begin
                if (ctl_phase != usbep0_pkg::PH_OUT)
                begin
                    return arm_for_setup();
                end
                sum       = {1'b0, out_bytes} + {10'd0, it.out_count};
                out_bytes = sum[16] ? 16'hFFFF : sum[15:0];
                out_tog   = ~out_tog;
                return arming(usbep0_pkg::ACT_OUT, '0, usbep0_pkg::SRC_NONE, '0, '0, out_tog);
            end
            usbep0_pkg::EV_IN_DONE:
            begin
                // the status stage of an address request commits the address
                if (dev_addr == 8'd0 && dev_st == usbep0_pkg::ST_ADDRESS)
                begin
                    dev_addr = pending_addr;
                    if (dev_addr == 8'd0)
                    begin
                        dev_st = usbep0_pkg::ST_DEFAULT;
                    end
                end
                if (ctl_phase != usbep0_pkg::PH_IN)
                begin
                    return arm_for_setup();
                end
                in_tog = ~in_tog;
                return next_in_packet();
            end
            usbep0_pkg::EV_STALL:
            begin
                return arm_for_setup();
            end
            default:
            begin
                return arming(usbep0_pkg::ACT_NONE, '0, usbep0_pkg::SRC_NONE, '0, '0, 1'b0);
            end
        endcase
    endfunction

    function automatic usbep0_pkg::item_t mk_event(input logic [2:0] ev,
                                                   input logic [7:0] rtype,
                                                   input logic [7:0] code,
                                                   input logic [15:0] val,
                                                   input logic [15:0] len,
                                                   input logic [6:0] cnt);
        usbep0_pkg::item_t it;
        it.req_type     = ev;
        it.request_type = rtype;
        it.request_code = code;
        it.value        = val;
        it.length       = len;
        it.out_count    = cnt;
        return it;
    endfunction

    function automatic usbep0_pkg::item_t random_event(input logic [2:0] ev);
        logic [6:0] cnt;
        if ($urandom_range(0, 19) == 0)
        begin
            cnt = 7'($urandom_range(0, 127));
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            cnt = 7'd64;
        end
        else
        begin
            cnt = 7'($urandom_range(0, 64));
        end
        return mk_event(ev, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), cnt);
    endfunction

    function automatic logic [15:0] random_wlength();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return 16'($urandom_range(0, 300));
        end
        if (r == 6)
        begin
            case ($urandom_range(0, 5))
                0:       return 16'd0;
                1:       return 16'd1;
                2:       return 16'd63;
                3:       return 16'd64;
                4:       return 16'd65;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 9)
        begin
            return 16'($urandom_range(0, 1200));
        end
        return 16'($urandom);
    endfunction

    function automatic usbep0_pkg::item_t random_setup();
        usbep0_pkg::item_t it;
        int                pick;
        it        = random_event(usbep0_pkg::EV_SETUP);
        it.length = random_wlength();
        pick      = $urandom_range(0, 99);
        if (pick < 35)
        begin
            it.request_type = usbep0_pkg::RT_STD_DEVICE_IN;
            it.request_code = usbep0_pkg::REQ_GET_DESCRIPTOR;
            case ($urandom_range(0, 3))
                0: it.value[15:8] = usbep0_pkg::DT_DEVICE;
                1: it.value[15:8] = usbep0_pkg::DT_CONFIG;
                2:
                begin
                    it.value[15:8] = usbep0_pkg::DT_STRING;
                    it.value[7:0]  = 8'($urandom_range(0, 5));
                end
                default:
                begin
                end
            endcase
        end
        else if (pick < 45)
        begin
            it.request_code = usbep0_pkg::REQ_SET_DEV_ADDR;
            if ($urandom_range(0, 3) != 0)
            begin
                it.request_type = 8'h00;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                it.value[7:0] = 8'h00;
            end
        end
        else if (pick < 55)
        begin
            it.request_type = 8'h00;
            it.request_code = usbep0_pkg::REQ_SET_CONFIGURATION;
            it.value[7:0]   = 8'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1));
        end
        else if (pick < 65)
        begin
            it.request_code = usbep0_pkg::REQ_GET_STATUS;
            it.request_type = usbep0_pkg::RT_STD_DEVICE_IN;
            if ($urandom_range(0, 2) == 0)
            begin
                it.request_type[4:0] = 5'($urandom);
            end
        end
        else if (pick < 72)
        begin
            it.request_type = 8'h81;
            it.request_code = usbep0_pkg::REQ_GET_INTERFACE;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0:       it.request_code = usbep0_pkg::REQ_GET_STATUS;
                1:       it.request_code = usbep0_pkg::REQ_SET_DEV_ADDR;
                2:       it.request_code = usbep0_pkg::REQ_GET_DESCRIPTOR;
                3:       it.request_code = usbep0_pkg::REQ_SET_CONFIGURATION;
                default: it.request_code = usbep0_pkg::REQ_GET_INTERFACE;
            endcase
        end
        return it;
    endfunction

    task automatic send_event(input usbep0_pkg::item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {1'b0, it.out_count, it.length, it.value, it.request_code,
                     it.request_type};
        do @(posedge clk); while (!s_tready);
        pending_arms.push_back(predict_arming(it));
        events_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold off until every pending arming has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_arms.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            usbep0_pkg::REG_DEVICE_DESC_LENGTH:  dev_desc_len = val[7:0];
            usbep0_pkg::REG_CONFIG_TOTAL_LENGTH: cfg_set_len  = val[15:0];
            usbep0_pkg::REG_STRING_COUNT:        str_count    = val[2:0];
            usbep0_pkg::REG_STRING0_LENGTH:      str_len[0]   = val[7:0];
            usbep0_pkg::REG_STRING1_LENGTH:      str_len[1]   = val[7:0];
            usbep0_pkg::REG_STRING2_LENGTH:      str_len[2]   = val[7:0];
            usbep0_pkg::REG_STRING3_LENGTH:      str_len[3]   = val[7:0];
            default:
            begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [7:0] dd, input logic [15:0] ct,
                                  input logic [2:0] sc, input logic [7:0] s0,
                                  input logic [7:0] s1, input logic [7:0] s2,
                                  input logic [7:0] s3);
        settle();
        write_reg(usbep0_pkg::REG_DEVICE_DESC_LENGTH, {24'd0, dd});
        write_reg(usbep0_pkg::REG_CONFIG_TOTAL_LENGTH, {16'd0, ct});
        write_reg(usbep0_pkg::REG_STRING_COUNT, {29'd0, sc});
        write_reg(usbep0_pkg::REG_STRING0_LENGTH, {24'd0, s0});
        write_reg(usbep0_pkg::REG_STRING1_LENGTH, {24'd0, s1});
        write_reg(usbep0_pkg::REG_STRING2_LENGTH, {24'd0, s2});
        write_reg(usbep0_pkg::REG_STRING3_LENGTH, {24'd0, s3});
        settings_used++;
    endtask

    task automatic run_transfer();
        int more;
        send_event(random_setup());
        if (ctl_phase == usbep0_pkg::PH_IN)
        begin
            more = (int'(reply_left) + usbep0_pkg::MAX_PACKET - 1) / usbep0_pkg::MAX_PACKET
                 + $urandom_range(0, 1);
            if (more > 8 && $urandom_range(0, 9) != 0)
            begin
                more = $urandom_range(0, 8);
            end
            else if (more > 40)
            begin
                more = 40;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                more = $urandom_range(0, more);
            end
            repeat (more) send_event(random_event(usbep0_pkg::EV_IN_DONE));
            if ($urandom_range(0, 9) != 0)
            begin
                send_event(random_event(usbep0_pkg::EV_OUT_DONE));
            end
            else
            begin
                send_event(random_event(3'($urandom_range(0, 7))));
            end
        end
        else if (ctl_phase == usbep0_pkg::PH_OUT)
        begin
            repeat ($urandom_range(0, 4)) send_event(random_event(usbep0_pkg::EV_OUT_DONE));
            if ($urandom_range(0, 9) != 0)
            begin
                send_event(random_event(usbep0_pkg::EV_IN_DONE));
            end
            else
            begin
                send_event(random_event(3'($urandom_range(0, 7))));
            end
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            send_event(random_event(usbep0_pkg::EV_STALL));
        end
    endtask

    task automatic run_random(input int n);
        int target;
        int r;
        target = events_sent + n;
        while (events_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                send_event(random_event(usbep0_pkg::EV_BUS_RESET));
            end
            else if (r < 8)
            begin
                send_event(random_event(3'($urandom_range(0, 7))));
            end
            else
            begin
                run_transfer();
            end
        end
    endtask

    task automatic test_enumeration();
        send_event(mk_event(usbep0_pkg::EV_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, usbep0_pkg::RT_STD_DEVICE_IN,
                            usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'hFFFF, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h00, usbep0_pkg::REQ_SET_DEV_ADDR,
                            16'hFF7F, 16'h0000, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                            7'd127));
        send_event(mk_event(usbep0_pkg::EV_SETUP, usbep0_pkg::RT_STD_DEVICE_IN,
                            usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0200, 16'h0000, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h00, usbep0_pkg::REQ_SET_CONFIGURATION,
                            16'h0001, 16'h0000, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd64));
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h81, usbep0_pkg::REQ_GET_INTERFACE,
                            16'h0000, 16'h0001, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
    endtask

    task automatic test_refused_requests();
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h82, usbep0_pkg::REQ_GET_STATUS,
                            16'h0000, 16'h0002, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_STALL, 8'h00, 8'h00, 16'h0000, 16'h0000, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, usbep0_pkg::RT_STD_DEVICE_IN,
                            usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0300, 16'h00FF, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h00, usbep0_pkg::REQ_GET_DESCRIPTOR,
                            16'h0100, 16'h0040, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, usbep0_pkg::RT_STD_DEVICE_IN,
                            usbep0_pkg::REQ_GET_DESCRIPTOR, 16'hFF00, 16'h0040, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h80, 8'hFF, 16'h0100, 16'h0040, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h80, usbep0_pkg::REQ_SET_DEV_ADDR,
                            16'h0011, 16'h0040, 7'd0));
        send_event(mk_event(3'd7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd127));
        send_event(mk_event(3'd5, 8'h00, 8'h00, 16'h0000, 16'h0000, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h00, usbep0_pkg::REQ_SET_DEV_ADDR,
                            16'h0000, 16'h0000, 7'd0));
        send_event(mk_event(usbep0_pkg::EV_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
    endtask

    task automatic test_out_saturation();
        usbep0_pkg::item_t it;
        send_event(mk_event(usbep0_pkg::EV_SETUP, 8'h00, usbep0_pkg::REQ_SET_CONFIGURATION,
                            16'h0002, 16'h0000, 7'd0));
        repeat (520)
        begin
            it           = random_event(usbep0_pkg::EV_OUT_DONE);
            it.out_count = 7'd127;
            send_event(it);
        end
        send_event(mk_event(usbep0_pkg::EV_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
        send_event(mk_event(usbep0_pkg::EV_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                            7'd0));
    endtask

    task automatic test_random_transfers();
        apply_settings(8'd18, 16'($urandom_range(9, 300)), 3'd4, 8'($urandom_range(2, 255)),
                       8'($urandom_range(2, 255)), 8'($urandom_range(2, 255)),
                       8'($urandom_range(2, 255)));
        run_random(RANDOM_EVENTS / 5);
        apply_settings(8'hFF, 16'hFFFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(RANDOM_EVENTS / 5);
        apply_settings(8'd0, 16'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_random(RANDOM_EVENTS / 5);
        apply_settings(8'($urandom), 16'($urandom), 3'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
        run_random(RANDOM_EVENTS / 5);
        apply_settings(8'd64, 16'd64, 3'd4, 8'd0, 8'd1, 8'd64, 8'd65);
        run_random(RANDOM_EVENTS / 5);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                     want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_arms.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected item, expected none, actual action %0d",
                         $time, m_tuser);
            end
            else
            begin
                want = pending_arms.pop_front();
                check_field("ep0_action", 32'(want.ep0_action), 32'(m_tuser));
                check_field("in_count", 32'(want.in_count), 32'(m_tdata[6:0]));
                check_field("source_select", 32'(want.source_select), 32'(m_tdata[9:7]));
                check_field("string_index", 32'(want.string_index), 32'(m_tdata[11:10]));
                check_field("source_offset", 32'(want.source_offset), 32'(m_tdata[27:12]));
                check_field("packet_toggle", 32'(want.packet_toggle), 32'(m_tdata[28]));
                check_field("out_total", 32'(want.out_total), 32'(m_tdata[44:29]));
                check_field("device_state", 32'(want.device_state), 32'(m_tdata[46:45]));
                check_field("bus_address", 32'(want.bus_address), 32'(m_tdata[54:47]));
                check_field("configuration", 32'(want.configuration), 32'(m_tdata[62:55]));
                case (want.ep0_action)
                    usbep0_pkg::ACT_IN:    seen_in++;
                    usbep0_pkg::ACT_OUT:   seen_out++;
                    usbep0_pkg::ACT_STALL: seen_stall++;
                    usbep0_pkg::ACT_SETUP: seen_setup++;
                    default:               seen_none++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rdy_span == 0)
        begin
            rdy_span = $urandom_range(8, 64);
            rdy_mode = $urandom_range(0, 3);
        end
        rdy_span--;
        rdy_phase++;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rdy_phase % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout with %0d armings outstanding", $time,
                     pending_arms.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        reset_engine_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_enumeration();
        test_refused_requests();
        test_out_saturation();
        test_random_transfers();
        settle();
        $display("Ran %0d events over %0d register settings (%0d register writes).",
                 events_sent, settings_used, reg_writes);
        $display("Checked %0d IN packets, %0d OUT arms, %0d stalls, %0d setup arms, %0d none.",
                 seen_in, seen_out, seen_stall, seen_setup, seen_none);
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
